### rtl/saes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saes_pkg
// types, constants and nibble functions of the simplified aes cipher
// ----------------------------------------------------------------------------
package saes_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // register index of the key, taken from the word address
  localparam logic RegCipherKey = 1'b0;

  // direction codes
  localparam logic KindEnc = 1'b0;
  localparam logic KindDec = 1'b1;

  localparam logic [7:0] Rcon1 = 8'h80;
  localparam logic [7:0] Rcon2 = 8'h30;
  localparam logic [3:0] GfPoly = 4'h3;

  typedef struct packed {
    logic [KeyW-1:0] rk0;
    logic [KeyW-1:0] rk1;
    logic [KeyW-1:0] rk2;
  } round_keys_t;

  typedef struct packed {
    logic              kind;
    logic [BlockW-1:0] data;
  } stage_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'd9;
      4'h1: r = 4'd4;
      4'h2: r = 4'd10;
      4'h3: r = 4'd11;
      4'h4: r = 4'd13;
      4'h5: r = 4'd1;
      4'h6: r = 4'd8;
      4'h7: r = 4'd5;
      4'h8: r = 4'd6;
      4'h9: r = 4'd2;
      4'ha: r = 4'd0;
      4'hb: r = 4'd3;
      4'hc: r = 4'd12;
      4'hd: r = 4'd14;
      4'he: r = 4'd15;
      4'hf: r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'd10;
      4'h1: r = 4'd5;
      4'h2: r = 4'd9;
      4'h3: r = 4'd11;
      4'h4: r = 4'd1;
      4'h5: r = 4'd7;
      4'h6: r = 4'd8;
      4'h7: r = 4'd15;
      4'h8: r = 4'd6;
      4'h9: r = 4'd0;
      4'ha: r = 4'd2;
      4'hb: r = 4'd3;
      4'hc: r = 4'd12;
      4'hd: r = 4'd4;
      4'he: r = 4'd13;
      4'hf: r = 4'd14;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_nib(input logic [BlockW-1:0] v,
                                                input logic inv);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = inv ? sbox_inv(v[4*i +: 4]) : sbox_fwd(v[4*i +: 4]);
    end
    return r;
  endfunction

  // swap nibbles n0 and n2
  function automatic logic [BlockW-1:0] shift_row(input logic [BlockW-1:0] v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  // multiply by x modulo x^4+x+1
  function automatic logic [3:0] gf_x(input logic [3:0] a);
    return {a[2:0], 1'b0} ^ (a[3] ? GfPoly : 4'h0);
  endfunction

  function automatic logic [7:0] mix_col(input logic [7:0] c, input logic inv);
    logic [3:0] a, b, a2, b2, a4, b4, a9, b9;
    a  = c[7:4];
    b  = c[3:0];
    a2 = gf_x(a);
    b2 = gf_x(b);
    a4 = gf_x(a2);
    b4 = gf_x(b2);
    a9 = gf_x(a4) ^ a;
    b9 = gf_x(b4) ^ b;
    if (inv) begin
      return {a9 ^ b2, a2 ^ b9};
    end
    return {a ^ b4, a4 ^ b};
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] v,
                                                    input logic inv);
    return {mix_col(v[15:8], inv), mix_col(v[7:0], inv)};
  endfunction

  function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rc);
    return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rc;
  endfunction

  function automatic round_keys_t expand_keys(input logic [KeyW-1:0] key);
    round_keys_t rk;
    logic [7:0] w2, w3, w4, w5;
    w2 = key[15:8] ^ key_g(key[7:0], Rcon1);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ key_g(w3, Rcon2);
    w5 = w4 ^ w3;
    rk.rk0 = key;
    rk.rk1 = {w2, w3};
    rk.rk2 = {w4, w5};
    return rk;
  endfunction

  // first stage: key add, nibble substitution, row shift
  function automatic logic [BlockW-1:0] stage1_fn(input logic kind,
                                                  input logic [BlockW-1:0] v,
                                                  input round_keys_t rk);
    logic [BlockW-1:0] t;
    t = v ^ ((kind == KindDec) ? rk.rk2 : rk.rk0);
    return shift_row(sub_nib(t, kind == KindDec));
  endfunction

  // middle stage: column mixing and the middle round key
  function automatic logic [BlockW-1:0] stage2_fn(input logic kind,
                                                  input logic [BlockW-1:0] v,
                                                  input round_keys_t rk);
    if (kind == KindDec) begin
      return mix_columns(v ^ rk.rk1, 1'b1);
    end
    return mix_columns(v, 1'b0) ^ rk.rk1;
  endfunction

  // last stage: nibble substitution, row shift, key add
  function automatic logic [BlockW-1:0] stage3_fn(input logic kind,
                                                  input logic [BlockW-1:0] v,
                                                  input round_keys_t rk);
    logic [BlockW-1:0] t;
    t = shift_row(sub_nib(v, kind == KindDec));
    return t ^ ((kind == KindDec) ? rk.rk0 : rk.rk2);
  endfunction

endpackage
`default_nettype wire

### rtl/saes_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saes_in_if / saes_out_if
// valid/ready channels for blocks into and results out of the cipher
// ----------------------------------------------------------------------------
interface saes_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] data_block;

  modport source (output valid, kind, data_block, input ready);
  modport sink   (input valid, kind, data_block, output ready);
endinterface

interface saes_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_block;

  modport source (output valid, result_block, input ready);
  modport sink   (input valid, result_block, output ready);
endinterface
`default_nettype wire

### rtl/saes_apb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saes_apb
// key register on an apb-style port, round keys expanded at the write
// ----------------------------------------------------------------------------
module saes_apb
  import saes_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output      logic [PdataW-1:0] prdata,
  output      logic              pready,
  output      round_keys_t       rk_o
);

  logic [KeyW-1:0] key_q;
  round_keys_t     rk_q;
  logic            key_we;

  assign pready = 1'b1;
  assign key_we = psel && penable && pwrite && (paddr[2] == RegCipherKey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      rk_q  <= expand_keys('0);
    end else if (key_we) begin
      key_q <= pwdata[KeyW-1:0];
      rk_q  <= expand_keys(pwdata[KeyW-1:0]);
    end
  end

  assign prdata = (paddr[2] == RegCipherKey) ? {{(PdataW-KeyW){1'b0}}, key_q} : '0;
  assign rk_o   = rk_q;

endmodule
`default_nettype wire

### rtl/saes_pipe_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saes_pipe_reg
// one pipeline register with valid bit and backpressure
// ----------------------------------------------------------------------------
module saes_pipe_reg
  import saes_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output      logic   ready_o,
  input  wire stage_t data_i,
  output      logic   valid_o,
  input  wire logic   ready_i,
  output      stage_t data_o
);

  logic   valid_q;
  stage_t data_q;

  // empty slot or the item in it leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### rtl/simplified_aes_cipher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simplified_aes_cipher_top
// 16-bit simplified aes cipher, three-stage pipeline, one item per cycle while the output keeps up
// ----------------------------------------------------------------------------
// The core takes one 16-bit block and a direction bit per item (kind 0
// encrypts, kind 1 decrypts) and returns one 16-bit block per item, in
// order. Items pass through three register stages: the first does the
// outer key addition with nibble substitution and row shift, the second the
// column mixing with the middle round key, the third the last substitution,
// row shift and key addition. A result is presented from the third stage
// register once its item has passed the first and second registers, and one
// item is accepted every cycle while the output side keeps up; each stage
// holds its item under backpressure and empty stages still take new items.
// The key is written at byte addresses 0-3 of the apb-style port; the three
// round keys are expanded from the written value in the same cycle and
// registered, so an item may follow the write at once.
// Write the key only while no items are in flight.
// ----------------------------------------------------------------------------
module simplified_aes_cipher_top
  import saes_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  saes_in_if.sink                in_i,
  saes_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output      logic [PdataW-1:0] prdata,
  output      logic              pready
);

  round_keys_t rk;

  // stage payloads in and out of each pipeline register
  stage_t s1_d, s1_q;
  stage_t s2_d, s2_q;
  stage_t s3_d, s3_q;
  logic   s1_valid, s2_valid, s3_valid;
  logic   s2_ready, s3_ready;

  saes_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rk_o    (rk)
  );

  // first round half: outer key, substitution, row shift
  always_comb begin
    s1_d.kind = in_i.kind;
    s1_d.data = stage1_fn(in_i.kind, in_i.data_block, rk);
  end

  saes_pipe_reg u_s1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (s1_d),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .data_o  (s1_q)
  );

  // column mixing around the middle round key
  always_comb begin
    s2_d.kind = s1_q.kind;
    s2_d.data = stage2_fn(s1_q.kind, s1_q.data, rk);
  end

  saes_pipe_reg u_s2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s2_d),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_q)
  );

  // final round half; this register is the output register
  always_comb begin
    s3_d.kind = s2_q.kind;
    s3_d.data = stage3_fn(s2_q.kind, s2_q.data, rk);
  end

  saes_pipe_reg u_s3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s3_d),
    .valid_o (s3_valid),
    .ready_i (out_o.ready),
    .data_o  (s3_q)
  );

  assign out_o.valid        = s3_valid;
  assign out_o.result_block = s3_q.data;

endmodule
`default_nettype wire
